/* src/eppk_pkg.sv */
`timescale 1ns / 1ps

package eppk_pkg;

  localparam int          SIG_W       = 64;
  localparam int          EXP_W       = 16;
  localparam logic [14:0] EXP_ALL_ONES = 15'h7FFF;
  localparam logic [15:0] EXP_BIAS    = 16'd16383;
  localparam logic [63:0] INT_BIT     = 64'h8000000000000000;
  localparam int          QUEUE_DEPTH = 2;

  localparam logic       KIND_UNPACK = 1'b0;
  localparam logic       KIND_PACK   = 1'b1;

  localparam logic [1:0] CLS_FINITE = 2'd0;
  localparam logic [1:0] CLS_INF    = 2'd1;
  localparam logic [1:0] CLS_NAN    = 2'd2;

  typedef enum logic [2:0] {
    OP_UNP_ZERO,
    OP_UNP_SPECIAL,
    OP_UNP_NORM,
    OP_PK_SPECIAL,
    OP_PK_ZERO,
    OP_PK_OVF,
    OP_PK_FIN,
    OP_PK_DENORM
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             sign;
    logic [1:0]       cls;
    logic [EXP_W-1:0] exp;
    logic [SIG_W-1:0] sig;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } state_t;

endpackage

/* src/eppk_front.sv */
`timescale 1ns / 1ps

module eppk_front (
  input  logic                kind,
  input  logic                sign,
  input  logic [14:0]         exp_field,
  input  logic [1:0]          in_class,
  input  logic signed [31:0]  in_exponent,
  input  logic [63:0]         significand,
  output eppk_pkg::entry_t    entry
);

  localparam logic signed [33:0] BIAS_S   = 34'sd16383;
  localparam logic signed [33:0] BE_MAX   = 34'sd32766;
  localparam logic signed [33:0] BE_FLUSH = -34'sd63;
  localparam logic signed [33:0] ONE_S    = 34'sd1;

  logic signed [33:0] be;
  logic signed [33:0] sh;
  logic [14:0]        ef_eff;

  assign be     = $signed({{2{in_exponent[31]}}, in_exponent}) + BIAS_S;
  assign sh     = ONE_S - be;
  assign ef_eff = (exp_field == 15'd0) ? 15'd1 : exp_field;

  always_comb begin
    entry.op   = eppk_pkg::OP_UNP_ZERO;
    entry.sign = sign;
    entry.cls  = eppk_pkg::CLS_FINITE;
    entry.exp  = '0;
    entry.sig  = significand;
    if (kind == eppk_pkg::KIND_UNPACK) begin
      if (significand == '0) begin
        entry.op = eppk_pkg::OP_UNP_ZERO;
      end else if (exp_field == eppk_pkg::EXP_ALL_ONES) begin
        entry.op  = eppk_pkg::OP_UNP_SPECIAL;
        entry.cls = (significand == eppk_pkg::INT_BIT) ? eppk_pkg::CLS_INF
                                                      : eppk_pkg::CLS_NAN;
      end else begin
        entry.op  = eppk_pkg::OP_UNP_NORM;
        entry.exp = {1'b0, ef_eff} - eppk_pkg::EXP_BIAS;
      end
    end else begin
      if (in_class == eppk_pkg::CLS_INF) begin
        entry.op  = eppk_pkg::OP_PK_SPECIAL;
        entry.sig = eppk_pkg::INT_BIT;
      end else if (in_class != eppk_pkg::CLS_FINITE) begin
        entry.op  = eppk_pkg::OP_PK_SPECIAL;
      end else if (significand == '0) begin
        entry.op  = eppk_pkg::OP_PK_ZERO;
      end else if (be > BE_MAX) begin
        entry.op  = eppk_pkg::OP_PK_OVF;
      end else if (be <= BE_FLUSH) begin
        entry.op  = eppk_pkg::OP_PK_ZERO;
      end else if (be <= 34'sd0) begin
        entry.op  = eppk_pkg::OP_PK_DENORM;
        entry.exp = {10'd0, sh[5:0]};
      end else begin
        entry.op  = eppk_pkg::OP_PK_FIN;
        entry.exp = be[15:0];
      end
    end
  end

endmodule

/* src/eppk_queue.sv */
`timescale 1ns / 1ps

module eppk_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  eppk_pkg::entry_t      wr_entry,
  input  logic                  pop,
  output eppk_pkg::entry_t      rd_entry,
  output eppk_pkg::q_status_t   status
);

  eppk_pkg::entry_t slots [eppk_pkg::QUEUE_DEPTH];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign status.full  = (count == 2'(eppk_pkg::QUEUE_DEPTH));
  assign status.empty = (count == 2'd0);
  assign rd_entry     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* src/eppk_back.sv */
`timescale 1ns / 1ps

module eppk_back (
  input  logic                 clk,
  input  logic                 rst,
  input  eppk_pkg::entry_t     rd_entry,
  input  eppk_pkg::q_status_t  status,
  output logic                 pop,
  output logic                 done,
  output logic [1:0]           out_class,
  output logic                 out_sign,
  output logic signed [15:0]   out_exponent,
  output logic [63:0]          out_significand,
  output logic [15:0]          out_sign_exponent,
  output logic                 overflow
);

  eppk_pkg::state_t state;
  eppk_pkg::state_t state_next;
  eppk_pkg::op_t    op;
  logic             sign;
  logic [1:0]       cls;
  logic [15:0]      exp;
  logic [63:0]      sig;

  logic             step;
  logic             finish;
  logic [2:0]       lz;

  logic [1:0]       out_class_next;
  logic             out_sign_next;
  logic [15:0]      out_exponent_next;
  logic [63:0]      out_significand_next;
  logic [15:0]      out_sign_exponent_next;
  logic             overflow_next;

  always_comb begin
    lz = 3'd7;
    for (int i = 0; i < 8; i++) begin
      if (sig[56 + i]) begin
        lz = 3'(7 - i);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      eppk_pkg::BK_IDLE: begin
        if (!status.empty) begin
          state_next = eppk_pkg::BK_RUN;
        end
      end
      eppk_pkg::BK_RUN: begin
        if (finish && status.empty) begin
          state_next = eppk_pkg::BK_IDLE;
        end
      end
      default: state_next = eppk_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    step   = 1'b0;
    finish = 1'b0;
    case (state)
      eppk_pkg::BK_IDLE: begin
        step   = 1'b0;
        finish = 1'b0;
      end
      eppk_pkg::BK_RUN: begin
        step   = (op == eppk_pkg::OP_UNP_NORM) && (sig[63:56] == 8'd0);
        finish = !step;
      end
      default: begin
        step   = 1'b0;
        finish = 1'b0;
      end
    endcase
    pop = ((state == eppk_pkg::BK_IDLE) || finish) && !status.empty;
  end

  always_comb begin
    out_class_next         = eppk_pkg::CLS_FINITE;
    out_sign_next          = 1'b0;
    out_exponent_next      = '0;
    out_significand_next   = '0;
    out_sign_exponent_next = '0;
    overflow_next          = 1'b0;
    case (op)
      eppk_pkg::OP_UNP_ZERO: begin
        out_sign_next = sign;
      end
      eppk_pkg::OP_UNP_SPECIAL: begin
        out_sign_next        = sign;
        out_class_next       = cls;
        out_significand_next = sig;
      end
      eppk_pkg::OP_UNP_NORM: begin
        out_sign_next        = sign;
        out_exponent_next    = exp - {13'd0, lz};
        out_significand_next = sig << lz;
      end
      eppk_pkg::OP_PK_SPECIAL: begin
        out_sign_exponent_next = {sign, eppk_pkg::EXP_ALL_ONES};
        out_significand_next   = sig;
      end
      eppk_pkg::OP_PK_ZERO: begin
        out_sign_exponent_next = {sign, 15'd0};
      end
      eppk_pkg::OP_PK_OVF: begin
        overflow_next = 1'b1;
      end
      eppk_pkg::OP_PK_FIN: begin
        out_sign_exponent_next = {sign, exp[14:0]};
        out_significand_next   = sig;
      end
      eppk_pkg::OP_PK_DENORM: begin
        out_sign_exponent_next = {sign, 15'd0};
        out_significand_next   = sig >> exp[5:0];
      end
      default: begin
        overflow_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= eppk_pkg::BK_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op   <= rd_entry.op;
      sign <= rd_entry.sign;
      cls  <= rd_entry.cls;
      exp  <= rd_entry.exp;
      sig  <= rd_entry.sig;
    end else if (step) begin
      exp <= exp - 16'd8;
      sig <= {sig[55:0], 8'd0};
    end
    if (finish) begin
      out_class         <= out_class_next;
      out_sign          <= out_sign_next;
      out_exponent      <= out_exponent_next;
      out_significand   <= out_significand_next;
      out_sign_exponent <= out_sign_exponent_next;
      overflow          <= overflow_next;
    end
  end

  a_done_from_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == eppk_pkg::BK_RUN))
    else $error("result strobe without a finishing step");

  a_norm_holds: assert property (@(posedge clk) disable iff (rst)
    step |=> (state == eppk_pkg::BK_RUN) && (op == eppk_pkg::OP_UNP_NORM))
    else $error("normalization left before completion");

  a_norm_result: assert property (@(posedge clk) disable iff (rst)
    (finish && (op == eppk_pkg::OP_UNP_NORM)) |=> out_significand[63])
    else $error("unpacked significand not normalized");

  a_ovf_clean: assert property (@(posedge clk) disable iff (rst)
    (done && overflow) |-> (out_significand == '0) && (out_sign_exponent == '0))
    else $error("overflow result carries a nonzero encoding");

endmodule

/* src/extended_precision_unpack_pack.sv */
`timescale 1ns / 1ps

// Converts between the 80-bit extended layout and an unpacked
// class/sign/exponent/significand form.
// Input: drive kind and the payload ports and raise start; a word is taken
// at a rising edge where start is high and busy is low. busy is high while
// the two-entry queue between the classifying front and the back is full.
// Output: done is high for exactly one cycle with the result on the out_*
// ports; the receiver cannot stall, so every result must be taken then.
// Unpack of a nonzero finite value adds a byte-wise shift step in the back
// for each whole leading zero byte of the significand (zero to seven); all
// other words take no such step.
// Throughput: one word per cycle except for normalization, which holds the
// back for its shift steps; the back's byte-wise shift loop sets that rate.
// Reset clears the queue and the back; results in flight are dropped.
module extended_precision_unpack_pack (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                kind,
  input  logic                sign,
  input  logic [14:0]         exp_field,
  input  logic [1:0]          in_class,
  input  logic signed [31:0]  in_exponent,
  input  logic [63:0]         significand,
  output logic                done,
  output logic [1:0]          out_class,
  output logic                out_sign,
  output logic signed [15:0]  out_exponent,
  output logic [63:0]         out_significand,
  output logic [15:0]         out_sign_exponent,
  output logic                overflow
);

  eppk_pkg::entry_t    wr_entry;
  eppk_pkg::entry_t    rd_entry;
  eppk_pkg::q_status_t status;
  logic                push;
  logic                pop;

  assign busy = status.full;
  assign push = start && !busy;

  eppk_front u_front (
    .kind        (kind),
    .sign        (sign),
    .exp_field   (exp_field),
    .in_class    (in_class),
    .in_exponent (in_exponent),
    .significand (significand),
    .entry       (wr_entry)
  );

  eppk_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (rd_entry),
    .status   (status)
  );

  eppk_back u_back (
    .clk               (clk),
    .rst               (rst),
    .rd_entry          (rd_entry),
    .status            (status),
    .pop               (pop),
    .done              (done),
    .out_class         (out_class),
    .out_sign          (out_sign),
    .out_exponent      (out_exponent),
    .out_significand   (out_significand),
    .out_sign_exponent (out_sign_exponent),
    .overflow          (overflow)
  );

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic               kind;
    logic               sgn;
    logic [14:0]        exp_field;
    logic [1:0]         cls;
    logic signed [31:0] exponent;
    logic [63:0]        sig;
    int                 gap;
    bit                 drain;
  } word_t;

  typedef struct {
    logic [1:0]         cls;
    logic               sgn;
    logic signed [15:0] exponent;
    logic [63:0]        sig;
    logic [15:0]        se;
    logic               ovf;
  } conv_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               kind;
  logic               sign;
  logic [14:0]        exp_field;
  logic [1:0]         in_class;
  logic signed [31:0] in_exponent;
  logic [63:0]        significand;
  logic               done;
  logic [1:0]         out_class;
  logic               out_sign;
  logic signed [15:0] out_exponent;
  logic [63:0]        out_significand;
  logic [15:0]        out_sign_exponent;
  logic               overflow;

  word_t word_q[$];
  conv_t conv_q[$];
  word_t cur;
  bit    cur_valid;
  logic  took;
  int    errors;

  extended_precision_unpack_pack dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .kind              (kind),
    .sign              (sign),
    .exp_field         (exp_field),
    .in_class          (in_class),
    .in_exponent       (in_exponent),
    .significand       (significand),
    .done              (done),
    .out_class         (out_class),
    .out_sign          (out_sign),
    .out_exponent      (out_exponent),
    .out_significand   (out_significand),
    .out_sign_exponent (out_sign_exponent),
    .overflow          (overflow)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic conv_t convert_word(word_t w);
    conv_t       r;
    logic [63:0] s;
    int          e;
    longint      be;
    longint      sh;
    r = '{default: '0};
    if (w.kind == eppk_pkg::KIND_UNPACK) begin
      r.sgn = w.sgn;
      if (w.sig == '0) begin
        r.cls = eppk_pkg::CLS_FINITE;
      end else if (w.exp_field == eppk_pkg::EXP_ALL_ONES) begin
        r.cls = (w.sig == eppk_pkg::INT_BIT) ? eppk_pkg::CLS_INF : eppk_pkg::CLS_NAN;
        r.sig = w.sig;
      end else begin
        e = (w.exp_field == '0) ? 1 : int'({17'b0, w.exp_field});
        e = e - int'(eppk_pkg::EXP_BIAS);
        s = w.sig;
        while (!s[63]) begin
          s = s << 1;
          e--;
        end
        r.exponent = e[15:0];
        r.sig = s;
      end
    end else begin
      if (w.cls >= eppk_pkg::CLS_NAN) begin
        r.se = {w.sgn, eppk_pkg::EXP_ALL_ONES};
        r.sig = w.sig;
      end else if (w.cls == eppk_pkg::CLS_INF) begin
        r.se = {w.sgn, eppk_pkg::EXP_ALL_ONES};
        r.sig = eppk_pkg::INT_BIT;
      end else if (w.sig == '0) begin
        r.se = {w.sgn, 15'd0};
      end else begin
        be = longint'(w.exponent) + longint'(eppk_pkg::EXP_BIAS);
        if (be > longint'(eppk_pkg::EXP_ALL_ONES) - 1) begin
          r.ovf = 1'b1;
        end else begin
          s = w.sig;
          if (be <= 0) begin
            sh = 1 - be;
            s = (sh >= 64) ? 64'd0 : (s >> sh);
            be = 0;
          end
          r.se = {w.sgn, be[14:0]};
          r.sig = s;
        end
      end
    end
    return r;
  endfunction

  task automatic add(input logic k, input logic s, input logic [14:0] ef,
                     input logic [1:0] c, input logic signed [31:0] x,
                     input logic [63:0] m, input bit dr);
    word_t w;
    w.kind = k;
    w.sgn = s;
    w.exp_field = ef;
    w.cls = c;
    w.exponent = x;
    w.sig = m;
    w.gap = 0;
    w.drain = dr;
    word_q.push_back(w);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    kind = 1'b0;
    sign = 1'b0;
    exp_field = '0;
    in_class = '0;
    in_exponent = '0;
    significand = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  always #5 clk = ~clk;

  // compare each result, then queue the prediction for the word taken here
  always @(posedge clk) begin
    conv_t want;
    word_t w;
    if (rst) begin
      took <= 1'b0;
    end else begin
      took <= start && !busy;
      if (done) begin
        if (conv_q.size() == 0) begin
          $error("result with no word outstanding");
          errors++;
        end else begin
          want = conv_q.pop_front();
          check_field("out_class", want.cls, out_class);
          check_field("out_sign", want.sgn, out_sign);
          check_field("out_exponent", want.exponent, out_exponent);
          check_field("out_significand", want.sig, out_significand);
          check_field("out_sign_exponent", want.se, out_sign_exponent);
          check_field("overflow", want.ovf, overflow);
        end
      end
      if (start && !busy) begin
        w.kind = kind;
        w.sgn = sign;
        w.exp_field = exp_field;
        w.cls = in_class;
        w.exponent = in_exponent;
        w.sig = significand;
        conv_q.push_back(convert_word(w));
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (took) cur_valid = 1'b0;
      if (!cur_valid && word_q.size() != 0) begin
        cur = word_q.pop_front();
        cur_valid = 1'b1;
      end
      if (cur_valid && cur.gap == 0 && !(cur.drain && conv_q.size() != 0)) begin
        start <= 1'b1;
        kind <= cur.kind;
        sign <= cur.sgn;
        exp_field <= cur.exp_field;
        in_class <= cur.cls;
        in_exponent <= cur.exponent;
        significand <= cur.sig;
      end else begin
        // hold off, scramble the idle payload
        if (cur_valid && cur.gap > 0) cur.gap--;
        start <= 1'b0;
        kind <= 1'($urandom_range(0, 1));
        sign <= 1'($urandom_range(0, 1));
        exp_field <= 15'($urandom);
        in_class <= 2'($urandom);
        in_exponent <= $urandom;
        significand <= rand64();
      end
    end
  end

  initial begin
    word_t w;
    int    i;
    int    r;

    add(eppk_pkg::KIND_UNPACK, 1, 15'h1234, 0, 0, 64'd0, 0);
    add(eppk_pkg::KIND_UNPACK, 0, eppk_pkg::EXP_ALL_ONES, 0, 0, eppk_pkg::INT_BIT, 0);
    add(eppk_pkg::KIND_UNPACK, 1, eppk_pkg::EXP_ALL_ONES, 0, 0, eppk_pkg::INT_BIT, 0);
    add(eppk_pkg::KIND_UNPACK, 0, eppk_pkg::EXP_ALL_ONES, 0, 0, 64'd1, 0);
    add(eppk_pkg::KIND_UNPACK, 1, eppk_pkg::EXP_ALL_ONES, 0, 0, '1, 0);
    add(eppk_pkg::KIND_UNPACK, 0, 15'd0, 0, 0, 64'd1, 0);
    add(eppk_pkg::KIND_UNPACK, 1, 15'd0, 0, 0, eppk_pkg::INT_BIT, 0);
    add(eppk_pkg::KIND_UNPACK, 0, 15'h7FFE, 0, 0, '1, 0);
    add(eppk_pkg::KIND_UNPACK, 0, 15'd1, 0, 0, 64'd1, 0);
    add(eppk_pkg::KIND_UNPACK, 1, 15'h3FFF, 0, 0, 64'h00FF_0000_1234_5678, 0);
    add(eppk_pkg::KIND_PACK, 1, 0, 2'd3, 32'sd5, 64'h1234, 0);
    add(eppk_pkg::KIND_PACK, 0, 0, eppk_pkg::CLS_NAN, 32'sd0, 64'hC000_0000_0000_0001, 0);
    add(eppk_pkg::KIND_PACK, 1, 0, eppk_pkg::CLS_INF, -32'sd7, 64'h55, 0);
    add(eppk_pkg::KIND_PACK, 1, 0, eppk_pkg::CLS_FINITE, 32'sd100, 64'd0, 0);
    add(eppk_pkg::KIND_PACK, 0, 0, eppk_pkg::CLS_FINITE, 32'sd16383, '1, 0);
    add(eppk_pkg::KIND_PACK, 1, 0, eppk_pkg::CLS_FINITE, 32'sd16384, eppk_pkg::INT_BIT, 0);
    add(eppk_pkg::KIND_PACK, 0, 0, eppk_pkg::CLS_FINITE, 32'h7FFF_FFFF, eppk_pkg::INT_BIT, 0);
    add(eppk_pkg::KIND_PACK, 1, 0, eppk_pkg::CLS_FINITE, 32'h8000_0000, '1, 0);
    add(eppk_pkg::KIND_PACK, 0, 0, eppk_pkg::CLS_FINITE, -32'sd16382, eppk_pkg::INT_BIT, 0);
    add(eppk_pkg::KIND_PACK, 1, 0, eppk_pkg::CLS_FINITE, -32'sd16383, '1, 0);
    add(eppk_pkg::KIND_PACK, 0, 0, eppk_pkg::CLS_FINITE, -32'sd16445, '1, 0);
    add(eppk_pkg::KIND_PACK, 0, 0, eppk_pkg::CLS_FINITE, -32'sd16446, '1, 0);
    add(eppk_pkg::KIND_PACK, 1, 0, eppk_pkg::CLS_FINITE, 32'sd3, 64'h0000_0000_00AB_CDEF, 0);
    add(eppk_pkg::KIND_PACK, 0, 0, eppk_pkg::CLS_FINITE, 32'sd0, 64'h8000_0000_0000_0001, 1);

    for (i = 0; i < 500; i++) begin
      w.kind = 1'($urandom_range(0, 1));
      w.sgn = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 9);
      w.exp_field = (r < 2) ? 15'd0 :
                    (r < 4) ? eppk_pkg::EXP_ALL_ONES :
                    (r == 4) ? 15'd1 :
                    (r == 5) ? 15'h7FFE : 15'($urandom);
      w.sig = rand64();
      r = $urandom_range(0, 9);
      if (r == 0) w.sig = '0;
      else if (r == 1) w.sig = eppk_pkg::INT_BIT;
      else if (r == 2) w.sig = '1;
      else if (r < 5) w.sig = w.sig >> $urandom_range(1, 63);
      r = $urandom_range(0, 7);
      w.cls = (r < 5) ? eppk_pkg::CLS_FINITE : 2'($urandom_range(1, 3));
      r = $urandom_range(0, 7);
      if (r == 0) w.exponent = $urandom;
      else if (r < 3) w.exponent = int'($urandom_range(0, 80)) - 16449;
      else if (r == 3) w.exponent = int'($urandom_range(0, 3)) + 16382;
      else w.exponent = int'($urandom_range(0, 32766)) - 16383;
      r = $urandom_range(0, 19);
      w.gap = (r < 13) ? 0 : (r < 18) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      w.drain = (i % 97 == 50);
      word_q.push_back(w);
    end

    @(negedge rst);
    while (word_q.size() != 0 || cur_valid || conv_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* filelist.f */
src/eppk_pkg.sv
src/eppk_front.sv
src/eppk_queue.sv
src/eppk_back.sv
src/extended_precision_unpack_pack.sv
test/tb.sv
